// ----- hdl/bfc_pkg.sv -----
// Shared types and codes for the ballot feeder controller.
// No dependencies; used by the top level and its checker.
package bfc_pkg;

    typedef enum logic [3:0] {
        ST_INIT    = 4'd0,
        ST_STANDBY = 4'd1,
        ST_WAIT    = 4'd2,
        ST_FEED    = 4'd3,
        ST_BARCODE = 4'd4,
        ST_DECIDE  = 4'd5,
        ST_CAST    = 4'd6,
        ST_SPOIL   = 4'd7,
        ST_EJECT   = 4'd8,
        ST_REMOVAL = 4'd9,
        ST_ABORT   = 4'd10
    } t_main_state;

    localparam logic [1:0] MOTOR_NONE = 2'd0;
    localparam logic [1:0] MOTOR_FWD  = 2'd1;
    localparam logic [1:0] MOTOR_STOP = 2'd2;

    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_EJECT = 2'd1;
    localparam logic [1:0] ACT_SPOIL = 2'd2;
    localparam logic [1:0] ACT_CAST  = 2'd3;

    localparam logic [1:0] LIGHTS_NONE = 2'd0;
    localparam logic [1:0] LIGHTS_ON   = 2'd1;
    localparam logic [1:0] LIGHTS_OFF  = 2'd2;

    localparam logic [2:0] MSG_NONE      = 3'd0;
    localparam logic [2:0] MSG_REMOVE    = 3'd1;
    localparam logic [2:0] MSG_CASTING   = 3'd2;
    localparam logic [2:0] MSG_DUPLICATE = 3'd3;
    localparam logic [2:0] MSG_PROMPT    = 3'd4;
    localparam logic [2:0] MSG_INVALID   = 3'd5;
    localparam logic [2:0] MSG_NO_CODE   = 3'd6;
    localparam logic [2:0] MSG_ERROR     = 3'd7;

    localparam logic [2:0] LOG_NONE     = 3'd0;
    localparam logic [2:0] LOG_CAST     = 3'd1;
    localparam logic [2:0] LOG_SPOIL    = 3'd2;
    localparam logic [2:0] LOG_TIMEOUT  = 3'd3;
    localparam logic [2:0] LOG_INVALID  = 3'd4;

    localparam logic [1:0] BTN_UP    = 2'd0;
    localparam logic [1:0] BTN_CAST  = 2'd1;
    localparam logic [1:0] BTN_SPOIL = 2'd2;

    localparam int EV_PAPER_IN   = 0;
    localparam int EV_PAPER_OUT  = 1;
    localparam int EV_CAST_DOWN  = 2;
    localparam int EV_CAST_UP    = 3;
    localparam int EV_SPOIL_DOWN = 4;
    localparam int EV_SPOIL_UP   = 5;
    localparam int EV_SCANNED    = 6;

    typedef struct packed {
        logic       paper;
        logic [1:0] button;
        logic       barcode;
    } t_sub;

endpackage

// ----- hdl/ballot_feeder_controller_top.sv -----
// An accepted word is held in the input stage, then registered into the result register.
// Throughput: one word per cycle while i_stall is low; input stage and result register advance together.
// o_stall rises in the same cycle as i_stall when both stages are full.
// Reset (i_rst_n low, synchronous): state goes to initialize, paper, button and
// barcode flags clear, both stages empty.
// Depends on bfc_pkg.
module ballot_feeder_controller_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [6:0] i_sensor_events,
    input  logic       i_scan_nonempty,
    input  logic       i_init_ok,
    input  logic       i_feed_timeout,
    input  logic       i_decision_timeout,
    input  logic       i_barcode_seen_before,
    input  logic       i_barcode_valid,
    input  logic       i_log_ok,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [3:0] o_main_state,
    output logic [1:0] o_motor_cmd,
    output logic [1:0] o_ballot_action,
    output logic [1:0] o_lights_cmd,
    output logic [2:0] o_display_msg,
    output logic       o_restart_feed_timer,
    output logic       o_restart_decision_timer,
    output logic [2:0] o_log_request,
    output logic       o_enter_standby,
    output logic       o_paper_present,
    output logic [1:0] o_button_state,
    output logic       o_barcode_present
);
    import bfc_pkg::*;

    logic        r_in_vld;
    logic [6:0]  r_ev;
    logic        r_nonempty, r_init_ok, r_feed_to, r_dec_to, r_seen, r_code_ok, r_log_ok;

    t_main_state r_state, n_state;
    t_sub        r_sub, n_sub, pre_sub;
    logic        upd_first;

    logic        r_out_vld;
    logic [1:0]  r_motor, n_motor, r_action, n_action, r_lights, n_lights;
    logic [2:0]  r_disp, n_disp, r_logreq, n_logreq;
    logic        r_rfeed, n_rfeed, r_rdec, n_rdec, r_stby, n_stby;

    logic        out_free, s1_adv, in_acc;

    function automatic t_sub sub_next(t_sub cur, logic [6:0] ev, logic nonempty);
        t_sub nx;
        nx = cur;
        if (!cur.paper) begin
            if (ev[EV_PAPER_IN]) nx.paper = 1'b1;
        end else begin
            if (ev[EV_PAPER_OUT]) nx.paper = 1'b0;
        end
        case (cur.button)
            BTN_UP: begin
                if (ev[EV_CAST_DOWN]) nx.button = BTN_CAST;
                else if (ev[EV_SPOIL_DOWN]) nx.button = BTN_SPOIL;
            end
            BTN_CAST: begin
                if (ev[EV_CAST_UP]) nx.button = BTN_UP;
            end
            BTN_SPOIL: begin
                if (ev[EV_SPOIL_UP]) nx.button = BTN_UP;
            end
            default: ;
        endcase
        if (!cur.barcode && ev[EV_SCANNED] && nonempty) nx.barcode = 1'b1;
        return nx;
    endfunction

    assign out_free = !r_out_vld || !i_stall;
    assign s1_adv   = r_in_vld && out_free;
    assign o_stall  = r_in_vld && !out_free;
    assign in_acc   = i_valid && !o_stall;

    always_comb begin
        n_state   = r_state;
        pre_sub   = r_sub;
        upd_first = 1'b0;
        n_motor   = MOTOR_NONE;
        n_action  = ACT_NONE;
        n_lights  = LIGHTS_NONE;
        n_disp    = MSG_NONE;
        n_rfeed   = 1'b0;
        n_rdec    = 1'b0;
        n_logreq  = LOG_NONE;
        n_stby    = 1'b0;
        unique case (r_state)
            ST_INIT: begin
                if (!r_init_ok) begin
                    n_state = ST_ABORT;
                end else begin
                    pre_sub   = sub_next(r_sub, r_ev, r_nonempty);
                    upd_first = 1'b1;
                    n_state   = pre_sub.paper ? ST_EJECT : ST_STANDBY;
                end
            end
            ST_STANDBY: begin
                pre_sub.barcode = 1'b0;
                n_stby          = 1'b1;
                n_state         = ST_WAIT;
            end
            ST_WAIT: begin
                if (r_sub.paper) begin
                    n_rfeed = 1'b1;
                    n_motor = MOTOR_FWD;
                    n_state = ST_FEED;
                end
            end
            ST_FEED: begin
                if (!r_sub.paper || r_feed_to) begin
                    n_motor = MOTOR_STOP;
                    if (r_sub.barcode) begin
                        n_state = ST_BARCODE;
                    end else begin
                        n_disp  = MSG_NO_CODE;
                        n_state = ST_EJECT;
                    end
                end
            end
            ST_BARCODE: begin
                if (r_seen) begin
                    n_disp  = MSG_DUPLICATE;
                    n_state = ST_EJECT;
                end else if (r_code_ok) begin
                    n_lights = LIGHTS_ON;
                    n_rdec   = 1'b1;
                    n_disp   = MSG_PROMPT;
                    n_state  = ST_DECIDE;
                end else begin
                    n_disp   = MSG_INVALID;
                    n_logreq = LOG_INVALID;
                    n_state  = ST_EJECT;
                end
            end
            ST_DECIDE: begin
                if (r_dec_to) begin
                    n_lights = LIGHTS_OFF;
                    n_logreq = LOG_TIMEOUT;
                    n_state  = ST_EJECT;
                end else if (r_sub.button == BTN_CAST) begin
                    n_logreq = LOG_CAST;
                    n_state  = r_log_ok ? ST_CAST : ST_ABORT;
                end else if (r_sub.button == BTN_SPOIL) begin
                    n_logreq = LOG_SPOIL;
                    n_state  = r_log_ok ? ST_SPOIL : ST_ABORT;
                end
            end
            ST_CAST: begin
                n_disp   = MSG_CASTING;
                n_action = ACT_CAST;
                n_state  = ST_STANDBY;
            end
            ST_SPOIL: begin
                n_action = ACT_SPOIL;
                n_disp   = MSG_REMOVE;
                n_state  = ST_REMOVAL;
            end
            ST_EJECT: begin
                n_action = ACT_EJECT;
                n_disp   = MSG_REMOVE;
                n_state  = ST_REMOVAL;
            end
            ST_REMOVAL: begin
                if (!r_sub.paper) n_state = ST_STANDBY;
            end
            ST_ABORT: begin
                n_disp = MSG_ERROR;
            end
            default: ;
        endcase
        if (n_state != ST_ABORT && !upd_first) n_sub = sub_next(pre_sub, r_ev, r_nonempty);
        else n_sub = pre_sub;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= ST_INIT;
            r_sub     <= '0;
            r_motor   <= MOTOR_NONE;
            r_action  <= ACT_NONE;
            r_lights  <= LIGHTS_NONE;
            r_disp    <= MSG_NONE;
            r_rfeed   <= 1'b0;
            r_rdec    <= 1'b0;
            r_logreq  <= LOG_NONE;
            r_stby    <= 1'b0;
        end else begin
            if (in_acc) r_in_vld <= 1'b1;
            else if (s1_adv) r_in_vld <= 1'b0;
            if (s1_adv) begin
                r_out_vld <= 1'b1;
                r_state   <= n_state;
                r_sub     <= n_sub;
                r_motor   <= n_motor;
                r_action  <= n_action;
                r_lights  <= n_lights;
                r_disp    <= n_disp;
                r_rfeed   <= n_rfeed;
                r_rdec    <= n_rdec;
                r_logreq  <= n_logreq;
                r_stby    <= n_stby;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ev       <= i_sensor_events;
            r_nonempty <= i_scan_nonempty;
            r_init_ok  <= i_init_ok;
            r_feed_to  <= i_feed_timeout;
            r_dec_to   <= i_decision_timeout;
            r_seen     <= i_barcode_seen_before;
            r_code_ok  <= i_barcode_valid;
            r_log_ok   <= i_log_ok;
        end
    end

    assign o_valid                  = r_out_vld;
    assign o_main_state             = r_state;
    assign o_motor_cmd              = r_motor;
    assign o_ballot_action          = r_action;
    assign o_lights_cmd             = r_lights;
    assign o_display_msg            = r_disp;
    assign o_restart_feed_timer     = r_rfeed;
    assign o_restart_decision_timer = r_rdec;
    assign o_log_request            = r_logreq;
    assign o_enter_standby          = r_stby;
    assign o_paper_present          = r_sub.paper;
    assign o_button_state           = r_sub.button;
    assign o_barcode_present        = r_sub.barcode;

endmodule

// ----- hdl/bfc_checker.sv -----
// Port-level checks for the ballot feeder controller, bound to its top level.
// Depends on bfc_pkg and ballot_feeder_controller_top.
module bfc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [3:0] o_main_state,
    input logic [1:0] o_motor_cmd,
    input logic [1:0] o_ballot_action,
    input logic [2:0] o_display_msg,
    input logic       o_restart_feed_timer,
    input logic       o_paper_present
);
    import bfc_pkg::*;

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output word dropped under stall");

    a_hold_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_main_state) && $stable(o_paper_present))
        else $error("stalled output word changed");

    a_error_abort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_display_msg == MSG_ERROR |-> o_main_state == ST_ABORT)
        else $error("error message outside abort");

    a_feed_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_restart_feed_timer |->
            o_motor_cmd == MOTOR_FWD && o_main_state == ST_FEED)
        else $error("feed timer restart without feed start");

    a_cast_standby: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_ballot_action == ACT_CAST |-> o_main_state == ST_STANDBY)
        else $error("cast not followed by standby");

endmodule

bind ballot_feeder_controller_top bfc_checker u_bfc_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .o_valid              (o_valid),
    .i_stall              (i_stall),
    .o_main_state         (o_main_state),
    .o_motor_cmd          (o_motor_cmd),
    .o_ballot_action      (o_ballot_action),
    .o_display_msg        (o_display_msg),
    .o_restart_feed_timer (o_restart_feed_timer),
    .o_paper_present      (o_paper_present)
);

// ----- tb/sv/tb_ballot_feeder_controller_top.sv -----
`timescale 1ns / 100ps
// Testbench for ballot_feeder_controller_top: directed ballot flows, shaped random ticks,
// and a final log-failure abort, each output word checked against an in-bench predictor.
// Depends on bfc_pkg and the controller RTL.
module tb_ballot_feeder_controller_top;
    import bfc_pkg::*;

    typedef struct packed {
        logic [6:0] events;
        logic       nonempty;
        logic       init_ok;
        logic       feed_to;
        logic       dec_to;
        logic       seen;
        logic       valid;
        logic       log_ok;
    } t_tick_word;

    typedef struct packed {
        logic [3:0] state;
        logic [1:0] motor;
        logic [1:0] action;
        logic [1:0] lights;
        logic [2:0] msg;
        logic       rfeed;
        logic       rdec;
        logic [2:0] log_req;
        logic       stby;
        logic       paper;
        logic [1:0] button;
        logic       barcode;
    } t_tick_cmds;

    localparam logic [6:0] EVM_PAPER_IN   = 7'(1 << EV_PAPER_IN);
    localparam logic [6:0] EVM_PAPER_OUT  = 7'(1 << EV_PAPER_OUT);
    localparam logic [6:0] EVM_CAST_DOWN  = 7'(1 << EV_CAST_DOWN);
    localparam logic [6:0] EVM_CAST_UP    = 7'(1 << EV_CAST_UP);
    localparam logic [6:0] EVM_SPOIL_DOWN = 7'(1 << EV_SPOIL_DOWN);
    localparam logic [6:0] EVM_SPOIL_UP   = 7'(1 << EV_SPOIL_UP);
    localparam logic [6:0] EVM_SCANNED    = 7'(1 << EV_SCANNED);
    localparam logic [6:0] EVM_ALL        = 7'h7F;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [6:0] i_sensor_events = '0;
    logic       i_scan_nonempty = 1'b0;
    logic       i_init_ok = 1'b0;
    logic       i_feed_timeout = 1'b0;
    logic       i_decision_timeout = 1'b0;
    logic       i_barcode_seen_before = 1'b0;
    logic       i_barcode_valid = 1'b0;
    logic       i_log_ok = 1'b0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [3:0] o_main_state;
    logic [1:0] o_motor_cmd;
    logic [1:0] o_ballot_action;
    logic [1:0] o_lights_cmd;
    logic [2:0] o_display_msg;
    logic       o_restart_feed_timer;
    logic       o_restart_decision_timer;
    logic [2:0] o_log_request;
    logic       o_enter_standby;
    logic       o_paper_present;
    logic [1:0] o_button_state;
    logic       o_barcode_present;

    t_main_state m_state = ST_INIT;
    logic        m_paper = 1'b0;
    logic [1:0]  m_button = BTN_UP;
    logic        m_barcode = 1'b0;

    t_tick_cmds tick_cmds_q[$];
    int         n_fail = 0;
    logic       no_idle = 1'b0;
    int         rx_accepts = 0;
    int         rx_seen = 0;
    int         rx_left = 0;

    ballot_feeder_controller_top u_dut (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_valid                 (i_valid),
        .o_stall                 (o_stall),
        .i_sensor_events         (i_sensor_events),
        .i_scan_nonempty         (i_scan_nonempty),
        .i_init_ok               (i_init_ok),
        .i_feed_timeout          (i_feed_timeout),
        .i_decision_timeout      (i_decision_timeout),
        .i_barcode_seen_before   (i_barcode_seen_before),
        .i_barcode_valid         (i_barcode_valid),
        .i_log_ok                (i_log_ok),
        .o_valid                 (o_valid),
        .i_stall                 (i_stall),
        .o_main_state            (o_main_state),
        .o_motor_cmd             (o_motor_cmd),
        .o_ballot_action         (o_ballot_action),
        .o_lights_cmd            (o_lights_cmd),
        .o_display_msg           (o_display_msg),
        .o_restart_feed_timer    (o_restart_feed_timer),
        .o_restart_decision_timer(o_restart_decision_timer),
        .o_log_request           (o_log_request),
        .o_enter_standby         (o_enter_standby),
        .o_paper_present         (o_paper_present),
        .o_button_state          (o_button_state),
        .o_barcode_present       (o_barcode_present)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(5_000_000);
        $display("Test completed with failures");
        $finish;
    end

    function automatic void note_failure(string text);
        n_fail++;
        if (n_fail <= 10) begin
            $display("%0t: %0s", $time, text);
        end
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            note_failure($sformatf("%0s mismatch: expected %0d actual %0d", name, want, got));
        end
    endfunction

    function automatic void update_sensors(logic [6:0] ev, logic nonempty);
        if (!m_paper) begin
            if (ev[EV_PAPER_IN]) m_paper = 1'b1;
        end else if (ev[EV_PAPER_OUT]) begin
            m_paper = 1'b0;
        end
        case (m_button)
            BTN_UP: begin
                if (ev[EV_CAST_DOWN]) m_button = BTN_CAST;
                else if (ev[EV_SPOIL_DOWN]) m_button = BTN_SPOIL;
            end
            BTN_CAST: begin
                if (ev[EV_CAST_UP]) m_button = BTN_UP;
            end
            BTN_SPOIL: begin
                if (ev[EV_SPOIL_UP]) m_button = BTN_UP;
            end
            default: ;
        endcase
        if (!m_barcode && ev[EV_SCANNED] && nonempty) m_barcode = 1'b1;
    endfunction

    function automatic t_tick_cmds run_tick(t_tick_word w);
        t_tick_cmds  c;
        logic        updated;
        t_main_state nxt;
        c = '0;
        updated = 1'b0;
        nxt = m_state;
        case (m_state)
            ST_INIT: begin
                if (!w.init_ok) begin
                    nxt = ST_ABORT;
                end else begin
                    update_sensors(w.events, w.nonempty);
                    updated = 1'b1;
                    nxt = m_paper ? ST_EJECT : ST_STANDBY;
                end
            end
            ST_STANDBY: begin
                m_barcode = 1'b0;
                c.stby = 1'b1;
                nxt = ST_WAIT;
            end
            ST_WAIT: begin
                if (m_paper) begin
                    c.rfeed = 1'b1;
                    c.motor = MOTOR_FWD;
                    nxt = ST_FEED;
                end
            end
            ST_FEED: begin
                if (!m_paper || w.feed_to) begin
                    c.motor = MOTOR_STOP;
                    if (m_barcode) begin
                        nxt = ST_BARCODE;
                    end else begin
                        c.msg = MSG_NO_CODE;
                        nxt = ST_EJECT;
                    end
                end
            end
            ST_BARCODE: begin
                if (w.seen) begin
                    c.msg = MSG_DUPLICATE;
                    nxt = ST_EJECT;
                end else if (w.valid) begin
                    c.lights = LIGHTS_ON;
                    c.rdec = 1'b1;
                    c.msg = MSG_PROMPT;
                    nxt = ST_DECIDE;
                end else begin
                    c.msg = MSG_INVALID;
                    c.log_req = LOG_INVALID;
                    nxt = ST_EJECT;
                end
            end
            ST_DECIDE: begin
                if (w.dec_to) begin
                    c.lights = LIGHTS_OFF;
                    c.log_req = LOG_TIMEOUT;
                    nxt = ST_EJECT;
                end else if (m_button == BTN_CAST) begin
                    c.log_req = LOG_CAST;
                    nxt = w.log_ok ? ST_CAST : ST_ABORT;
                end else if (m_button == BTN_SPOIL) begin
                    c.log_req = LOG_SPOIL;
                    nxt = w.log_ok ? ST_SPOIL : ST_ABORT;
                end
            end
            ST_CAST: begin
                c.msg = MSG_CASTING;
                c.action = ACT_CAST;
                nxt = ST_STANDBY;
            end
            ST_SPOIL: begin
                c.action = ACT_SPOIL;
                c.msg = MSG_REMOVE;
                nxt = ST_REMOVAL;
            end
            ST_EJECT: begin
                c.action = ACT_EJECT;
                c.msg = MSG_REMOVE;
                nxt = ST_REMOVAL;
            end
            ST_REMOVAL: begin
                if (!m_paper) nxt = ST_STANDBY;
            end
            ST_ABORT: begin
                c.msg = MSG_ERROR;
            end
            default: ;
        endcase
        m_state = nxt;
        if (nxt != ST_ABORT && !updated) update_sensors(w.events, w.nonempty);
        c.state = m_state;
        c.paper = m_paper;
        c.button = m_button;
        c.barcode = m_barcode;
        return c;
    endfunction

    function automatic t_tick_word mk_word(logic [6:0] ev, logic nonempty);
        t_tick_word w;
        w = '0;
        w.events = ev;
        w.nonempty = nonempty;
        w.init_ok = 1'b1;
        w.log_ok = 1'b1;
        return w;
    endfunction

    // Bias events toward the step the ballot flow is waiting for.
    function automatic t_tick_word shaped_word();
        t_tick_word w;
        for (int b = 0; b < 7; b++) w.events[b] = ($urandom_range(0, 7) == 0);
        w.nonempty = ($urandom_range(0, 3) != 0);
        w.init_ok = 1'($urandom_range(0, 1));
        w.feed_to = ($urandom_range(0, 7) == 0);
        w.dec_to = ($urandom_range(0, 15) == 0);
        w.seen = ($urandom_range(0, 3) == 0);
        w.valid = ($urandom_range(0, 3) != 0);
        w.log_ok = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 15) begin
            w.events = 7'($urandom_range(0, 127));
        end else begin
            case (m_state)
                ST_STANDBY: begin
                    if ($urandom_range(0, 1) == 0) w.events[EV_SCANNED] = 1'b1;
                end
                ST_WAIT: begin
                    if (!m_paper && $urandom_range(0, 4) < 3) w.events[EV_PAPER_IN] = 1'b1;
                    if ($urandom_range(0, 1) == 0) w.events[EV_SCANNED] = 1'b1;
                end
                ST_FEED: begin
                    if (m_paper && $urandom_range(0, 4) < 2) w.events[EV_PAPER_OUT] = 1'b1;
                end
                ST_DECIDE: begin
                    if (m_button == BTN_UP && $urandom_range(0, 1) == 0) begin
                        if ($urandom_range(0, 1) == 0) w.events[EV_CAST_DOWN] = 1'b1;
                        else w.events[EV_SPOIL_DOWN] = 1'b1;
                    end
                end
                ST_REMOVAL: begin
                    if (m_paper && $urandom_range(0, 1) == 0) w.events[EV_PAPER_OUT] = 1'b1;
                end
                default: ;
            endcase
            if (m_button == BTN_CAST && $urandom_range(0, 3) == 0) w.events[EV_CAST_UP] = 1'b1;
            if (m_button == BTN_SPOIL && $urandom_range(0, 3) == 0) w.events[EV_SPOIL_UP] = 1'b1;
        end
        // hold off the sticky abort until the final test
        if (m_state == ST_DECIDE && !w.dec_to && m_button != BTN_UP) w.log_ok = 1'b1;
        return w;
    endfunction

    task automatic send_tick(t_tick_word w);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_sensor_events <= w.events;
        i_scan_nonempty <= w.nonempty;
        i_init_ok <= w.init_ok;
        i_feed_timeout <= w.feed_to;
        i_decision_timeout <= w.dec_to;
        i_barcode_seen_before <= w.seen;
        i_barcode_valid <= w.valid;
        i_log_ok <= w.log_ok;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        tick_cmds_q.push_back(run_tick(w));
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (tick_cmds_q.size() != 0) @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (rx_seen != rx_accepts) begin
            rx_seen = rx_accepts;
            rx_left = no_idle ? 0 : $urandom_range(0, 6);
        end
        if (rx_left > 0) begin
            i_stall <= 1'b1;
            rx_left = rx_left - 1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_tick_cmds got;
        t_tick_cmds want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_main_state, o_motor_cmd, o_ballot_action, o_lights_cmd, o_display_msg,
                   o_restart_feed_timer, o_restart_decision_timer, o_log_request,
                   o_enter_standby, o_paper_present, o_button_state, o_barcode_present};
            if (tick_cmds_q.size() == 0) begin
                note_failure("output word with nothing pending");
            end else begin
                want = tick_cmds_q.pop_front();
                check_field("main_state", want.state, got.state);
                check_field("motor_cmd", want.motor, got.motor);
                check_field("ballot_action", want.action, got.action);
                check_field("lights_cmd", want.lights, got.lights);
                check_field("display_msg", want.msg, got.msg);
                check_field("restart_feed_timer", want.rfeed, got.rfeed);
                check_field("restart_decision_timer", want.rdec, got.rdec);
                check_field("log_request", want.log_req, got.log_req);
                check_field("enter_standby", want.stby, got.stby);
                check_field("paper_present", want.paper, got.paper);
                check_field("button_state", want.button, got.button);
                check_field("barcode_present", want.barcode, got.barcode);
            end
            rx_accepts = rx_accepts + 1;
        end
    end

    task automatic test_power_up();
        send_tick(mk_word(EVM_PAPER_IN | EVM_CAST_DOWN, 1'b0));
        send_tick(mk_word('0, 1'b0));
        send_tick(mk_word(EVM_PAPER_OUT | EVM_CAST_UP, 1'b0));
        send_tick(mk_word('0, 1'b0));
    endtask

    task automatic test_cast_path();
        t_tick_word w;
        send_tick(mk_word(EVM_SCANNED, 1'b1));
        send_tick(mk_word(EVM_PAPER_IN, 1'b0));
        send_tick(mk_word('0, 1'b0));
        send_tick(mk_word(EVM_PAPER_OUT, 1'b0));
        send_tick(mk_word('0, 1'b0));
        w = mk_word('0, 1'b0);
        w.valid = 1'b1;
        send_tick(w);
        send_tick(mk_word(EVM_CAST_DOWN | EVM_SPOIL_DOWN, 1'b0));
        send_tick(mk_word('0, 1'b0));
        send_tick(mk_word('0, 1'b0));
    endtask

    task automatic test_spoil_path();
        t_tick_word w;
        send_tick(mk_word(EVM_CAST_UP | EVM_SCANNED, 1'b0));
        send_tick(mk_word(EVM_PAPER_IN | EVM_SCANNED, 1'b1));
        send_tick(mk_word('0, 1'b0));
        w = mk_word('0, 1'b0);
        w.feed_to = 1'b1;
        send_tick(w);
        w = mk_word('0, 1'b0);
        w.valid = 1'b1;
        send_tick(w);
        send_tick(mk_word(EVM_SPOIL_DOWN, 1'b0));
        send_tick(mk_word('0, 1'b0));
        send_tick(mk_word('0, 1'b0));
        send_tick(mk_word(EVM_PAPER_OUT | EVM_SPOIL_UP, 1'b0));
        send_tick(mk_word('0, 1'b0));
    endtask

    task automatic test_random_traffic(int count);
        for (int i = 0; i < count; i++) begin
            if (i % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
            if (i == count / 2) wait_idle();
            send_tick(shaped_word());
        end
        no_idle = 1'b0;
    endtask

    task automatic test_log_failure_abort();
        t_tick_word w;
        while (!(m_state == ST_DECIDE && m_button != BTN_UP)) begin
            w = shaped_word();
            if (m_state == ST_DECIDE) w.dec_to = 1'b0;
            send_tick(w);
        end
        w = mk_word('0, 1'b0);
        w.log_ok = 1'b0;
        send_tick(w);
        send_tick(mk_word(EVM_ALL, 1'b1));
        for (int i = 0; i < 4; i++) send_tick(shaped_word());
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_power_up();
        wait_idle();
        test_cast_path();
        wait_idle();
        test_spoil_path();
        wait_idle();
        test_random_traffic(1600);
        test_log_failure_abort();
        wait_idle();
        repeat (8) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
